FILE: rtl/core/utc_calendar_check_and_fat_stamp_top_macros.svh
// Assertion macros for the calendar check and FAT stamp top level.
`ifndef UTC_CALENDAR_CHECK_AND_FAT_STAMP_TOP_MACROS_SVH
`define UTC_CALENDAR_CHECK_AND_FAT_STAMP_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk and disabled in reset.
`define UCFS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled in reset.
`define UCFS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ucfs_pkg.sv
// Types, constants and lookup functions for the calendar check and FAT stamp pipeline.
package ucfs_pkg;

    localparam logic [15:0] YEAR_FIRST     = 16'd2000;
    localparam logic [15:0] YEAR_LAST      = 16'd2099;
    localparam logic [15:0] FAT_EPOCH_YEAR = 16'd1980;
    localparam logic [31:0] FAT_FALLBACK   = 32'h0021_0000;
    localparam logic [7:0]  WEEKDAY_OFFSET = 8'd5;
    localparam logic [3:0]  WEEK_LENGTH    = 4'd7;
    localparam logic [15:0] DAYS_PER_YEAR  = 16'd365;
    localparam logic [7:0]  HOURS_PER_DAY  = 8'd24;
    localparam logic [7:0]  MINUTES_PER_HR = 8'd60;
    localparam logic [7:0]  SECONDS_PER_MN = 8'd60;
    localparam logic [7:0]  MONTH_FEB      = 8'd2;

    typedef struct packed {
        logic       ok;
        logic       trusted;
        logic [6:0] year_fat;
        logic [6:0] year_off;
        logic [8:0] month_start;
        logic [3:0] month_res;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] sec_half;
    } chk_t;

    typedef struct packed {
        logic        ok;
        logic        trusted;
        logic [15:0] days;
        logic [7:0]  resid;
        logic [31:0] stamp;
    } sum_t;

    typedef struct packed {
        logic        calendar_ok;
        logic [31:0] fat_stamp;
        logic [2:0]  weekday;
        logic [15:0] days_since_2000;
    } res_t;

    function automatic logic [4:0] month_len_f(input logic [7:0] m);
        logic [4:0] len;
        case (m)
            8'd1:    len = 5'd31;
            8'd2:    len = 5'd28;
            8'd3:    len = 5'd31;
            8'd4:    len = 5'd30;
            8'd5:    len = 5'd31;
            8'd6:    len = 5'd30;
            8'd7:    len = 5'd31;
            8'd8:    len = 5'd31;
            8'd9:    len = 5'd30;
            8'd10:   len = 5'd31;
            8'd11:   len = 5'd30;
            8'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] month_start_f(input logic [7:0] m);
        logic [8:0] st;
        case (m)
            8'd1:    st = 9'd0;
            8'd2:    st = 9'd31;
            8'd3:    st = 9'd59;
            8'd4:    st = 9'd90;
            8'd5:    st = 9'd120;
            8'd6:    st = 9'd151;
            8'd7:    st = 9'd181;
            8'd8:    st = 9'd212;
            8'd9:    st = 9'd243;
            8'd10:   st = 9'd273;
            8'd11:   st = 9'd304;
            8'd12:   st = 9'd334;
            default: st = 9'd0;
        endcase
        return st;
    endfunction

    // Month start in days, reduced modulo one week.
    function automatic logic [2:0] month_res_f(input logic [7:0] m);
        logic [2:0] r;
        case (m)
            8'd1:    r = 3'd0;
            8'd2:    r = 3'd3;
            8'd3:    r = 3'd3;
            8'd4:    r = 3'd6;
            8'd5:    r = 3'd1;
            8'd6:    r = 3'd4;
            8'd7:    r = 3'd6;
            8'd8:    r = 3'd2;
            8'd9:    r = 3'd5;
            8'd10:   r = 3'd0;
            8'd11:   r = 3'd3;
            8'd12:   r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/ucfs_check.sv
// First stage: range checks, leap year and month table lookups.
module ucfs_check (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [15:0]  year,
    input  logic [7:0]   month,
    input  logic [7:0]   day,
    input  logic [7:0]   hour,
    input  logic [7:0]   minute,
    input  logic [7:0]   second,
    input  logic         clock_marked,
    output logic         out_valid,
    input  logic         out_ready,
    output ucfs_pkg::chk_t out_data
);
    import ucfs_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    chk_t       data_reg;
    chk_t       data_next;
    logic       leap;
    logic       feb_extra;
    logic [4:0] dim;
    logic       ok;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        leap      = (year[1:0] == 2'b00);
        feb_extra = leap && (month == MONTH_FEB);
        dim       = month_len_f(month) + {4'd0, feb_extra};
        ok = (year >= YEAR_FIRST) && (year <= YEAR_LAST) &&
             (day != 8'd0) && (day <= {3'd0, dim}) &&
             (hour < HOURS_PER_DAY) && (minute < MINUTES_PER_HR) &&
             (second < SECONDS_PER_MN);

        data_next.ok          = ok;
        data_next.trusted     = ok && clock_marked;
        data_next.year_fat    = 7'(year - FAT_EPOCH_YEAR);
        data_next.year_off    = 7'(year - YEAR_FIRST);
        data_next.month_start = month_start_f(month) + {8'd0, leap && (month > MONTH_FEB)};
        data_next.month_res   = {1'b0, month_res_f(month)} + {3'd0, leap && (month > MONTH_FEB)};
        data_next.month       = month[3:0];
        data_next.day         = day[4:0];
        data_next.hour        = hour[4:0];
        data_next.minute      = minute[5:0];
        data_next.sec_half    = second[5:1];

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/core/ucfs_days.sv
// Second stage: day count, weekday residue sum and FAT word packing.
module ucfs_days (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  ucfs_pkg::chk_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ucfs_pkg::sum_t out_data
);
    import ucfs_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    sum_t       data_reg;
    sum_t       data_next;
    logic [7:0] quad;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        quad = (8'(in_data.year_off) + 8'd3) >> 2;

        data_next.ok      = in_data.ok;
        data_next.trusted = in_data.trusted;
        data_next.days    = 16'(in_data.year_off) * DAYS_PER_YEAR + 16'(quad) +
                            16'(in_data.month_start) + 16'(in_data.day) - 16'd1;
        data_next.resid   = 8'(in_data.year_off) + quad + 8'(in_data.month_res) +
                            8'(in_data.day) + (WEEKDAY_OFFSET - 8'd1);
        data_next.stamp   = {in_data.year_fat, in_data.month, in_data.day,
                             in_data.hour, in_data.minute, in_data.sec_half};

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/core/ucfs_pack.sv
// Third stage: weekday reduction, fallback selection and output register.
module ucfs_pack (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  ucfs_pkg::sum_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ucfs_pkg::res_t out_data
);
    import ucfs_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    res_t       data_reg;
    res_t       data_next;
    logic [4:0] fold1;
    logic [3:0] fold2;
    logic [3:0] wmod;

    assign in_ready = !valid_reg || out_ready;

    // Eight is one more than a week, so summing octal digits keeps the residue.
    always_comb begin
        fold1 = 5'(in_data.resid[7:6]) + 5'(in_data.resid[5:3]) + 5'(in_data.resid[2:0]);
        fold2 = 4'(fold1[4:3]) + 4'(fold1[2:0]);
        wmod  = (fold2 >= WEEK_LENGTH) ? (fold2 - WEEK_LENGTH) : fold2;

        data_next.calendar_ok = in_data.ok;
        if (in_data.trusted) begin
            data_next.fat_stamp       = in_data.stamp;
            data_next.weekday         = 3'(wmod + 4'd1);
            data_next.days_since_2000 = in_data.days;
        end else begin
            data_next.fat_stamp       = FAT_FALLBACK;
            data_next.weekday         = 3'd0;
            data_next.days_since_2000 = 16'd0;
        end

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/core/utc_calendar_check_and_fat_stamp_top.sv
// Top level of the calendar check and FAT date-time stamp pipeline.
// Each transaction carries one calendar reading and yields exactly one result transaction
// from the last stage; unless the output stalls, throughput is one reading per cycle.
// The three register stages (range check, day count, weekday and output select) each
// hold their transaction when the next stage is full, and any bubble is filled at once.
// The result holds a calendar_ok flag, the day count since 2000-01-01, the weekday
// (1 to 7, Saturday for 2000-01-01) and the FAT word; an invalid or untrusted reading
// gives the 1980-01-01 fallback word and zero day count and weekday.
module utc_calendar_check_and_fat_stamp_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // year[15:0], month[23:16], day[31:24], hour[39:32], minute[47:40], second[55:48]
    input  logic [55:0] s_axis_tdata,
    // clock_marked[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fat_stamp[31:0], weekday[34:32], days_since_2000[50:35], zero[55:51]
    output logic [55:0] m_axis_tdata,
    // calendar_ok[0]
    output logic        m_axis_tuser
);
    import ucfs_pkg::*;

    `include "utc_calendar_check_and_fat_stamp_top_macros.svh"

    logic chk_valid;
    logic chk_ready;
    chk_t chk_data;
    logic sum_valid;
    logic sum_ready;
    sum_t sum_data;
    res_t res_data;

    ucfs_check u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .year         (s_axis_tdata[15:0]),
        .month        (s_axis_tdata[23:16]),
        .day          (s_axis_tdata[31:24]),
        .hour         (s_axis_tdata[39:32]),
        .minute       (s_axis_tdata[47:40]),
        .second       (s_axis_tdata[55:48]),
        .clock_marked (s_axis_tuser),
        .out_valid    (chk_valid),
        .out_ready    (chk_ready),
        .out_data     (chk_data)
    );

    ucfs_days u_days (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chk_valid),
        .in_ready  (chk_ready),
        .in_data   (chk_data),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_data  (sum_data)
    );

    ucfs_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_data   (sum_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res_data)
    );

    assign m_axis_tdata = {5'd0, res_data.days_since_2000, res_data.weekday, res_data.fat_stamp};
    assign m_axis_tuser = res_data.calendar_ok;

    `UCFS_ASSERT_IMP(a_invalid_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[50:32] == 19'd0, "invalid reading carries a day count or weekday")
    `UCFS_ASSERT_IMP(a_no_weekday_fallback, m_axis_tvalid && (m_axis_tdata[34:32] == 3'd0), m_axis_tdata[31:0] == FAT_FALLBACK, "zero weekday without fallback stamp")
    `UCFS_ASSERT_NXT(a_stage_hold, chk_valid && !chk_ready, chk_valid && $stable(chk_data), "first stage dropped a stalled transaction")

endmodule

FILE: test/tb.sv
// Self-checking stream testbench for the calendar check and FAT stamp block.
module tb;
    import ucfs_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int IDLE_LIMIT  = 3000;
    localparam int RANDOM_ITEMS = 600;
    localparam int PRINT_LIMIT = 30;

    typedef struct {
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic        marked;
    } reading_t;

    typedef struct {
        logic        calendar_ok;
        logic [31:0] fat_stamp;
        logic [2:0]  weekday;
        logic [15:0] days_since_2000;
    } stamp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;

    reading_t pending_readings[$];
    stamp_t   expected_stamps[$];

    int mismatch_count = 0;
    int taken_count = 0;
    int s_gap = 0;
    int s_calm = 0;
    int m_stall = 0;
    int m_calm = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int idle_cycles = 0;

    int unsigned month_length_tbl[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int unsigned days_before_month[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                          304, 334};

    utc_calendar_check_and_fat_stamp_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic int unsigned month_days(int unsigned y, int unsigned m);
        if (m == 0 || m > 12) begin
            return 0;
        end
        return month_length_tbl[m - 1] + ((m == 2 && y % 4 == 0) ? 1 : 0);
    endfunction

    function automatic stamp_t predict_stamp(reading_t rd);
        stamp_t      res;
        int unsigned y;
        int unsigned yo;
        int unsigned days;
        bit          ok;
        y = rd.year;
        ok = y >= YEAR_FIRST && y <= YEAR_LAST && rd.day != 0 &&
             rd.day <= month_days(y, rd.month) &&
             rd.hour < 24 && rd.minute < 60 && rd.second < 60;
        res.calendar_ok = ok;
        res.fat_stamp = FAT_FALLBACK;
        res.weekday = '0;
        res.days_since_2000 = '0;
        if (ok && rd.marked) begin
            yo = y - YEAR_FIRST;
            days = 365 * yo + (yo + 3) / 4 + days_before_month[rd.month - 1] + rd.day - 1;
            if (rd.month > 2 && y % 4 == 0) begin
                days = days + 1;
            end
            res.days_since_2000 = days[15:0];
            res.weekday = 3'((days + WEEKDAY_OFFSET) % WEEK_LENGTH + 1);
            res.fat_stamp = ((y - FAT_EPOCH_YEAR) << 25) | (32'(rd.month) << 21) |
                            (32'(rd.day) << 16) | (32'(rd.hour) << 11) |
                            (32'(rd.minute) << 5) | 32'(rd.second / 2);
        end
        return res;
    endfunction

    function automatic reading_t make_reading(int unsigned y, int unsigned mo, int unsigned d,
                                              int unsigned h, int unsigned mi, int unsigned s,
                                              bit marked);
        reading_t rd;
        rd.year = y[15:0];
        rd.month = mo[7:0];
        rd.day = d[7:0];
        rd.hour = h[7:0];
        rd.minute = mi[7:0];
        rd.second = s[7:0];
        rd.marked = marked;
        return rd;
    endfunction

    // Mostly well-formed readings, some with one field pushed out of range, some noise.
    function automatic reading_t random_reading();
        reading_t    rd;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        rd.year = 16'($urandom_range(2000, 2099));
        rd.month = 8'($urandom_range(1, 12));
        rd.day = 8'($urandom_range(1, month_days(rd.year, rd.month)));
        rd.hour = 8'($urandom_range(0, 23));
        rd.minute = 8'($urandom_range(0, 59));
        rd.second = 8'($urandom_range(0, 59));
        rd.marked = $urandom_range(0, 99) < 85;
        if (pick >= 65 && pick < 88) begin
            case ($urandom_range(0, 7))
                0: rd.year = $urandom_range(0, 1) ? 16'd1999 : 16'd2100;
                1: rd.month = $urandom_range(0, 1) ? 8'd0 : 8'd13;
                2: rd.day = 8'(month_days(rd.year, rd.month) + 1);
                3: rd.day = 8'd0;
                4: rd.hour = 8'($urandom_range(24, 255));
                5: rd.minute = 8'($urandom_range(60, 255));
                6: rd.second = 8'($urandom_range(60, 255));
                default: rd.year = 16'($urandom);
            endcase
        end else if (pick >= 88) begin
            rd.year = 16'($urandom);
            rd.month = 8'($urandom);
            rd.day = 8'($urandom);
            rd.hour = 8'($urandom);
            rd.minute = 8'($urandom);
            rd.second = 8'($urandom);
            rd.marked = 1'($urandom);
        end
        return rd;
    endfunction

    function automatic int gap_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end else if (pick < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got,
                     want);
        end
        mismatch_count++;
    endtask

    initial begin
        pending_readings.push_back(make_reading(2000, 1, 1, 0, 0, 0, 1));
        pending_readings.push_back(make_reading(2099, 12, 31, 23, 59, 59, 1));
        pending_readings.push_back(make_reading(2000, 2, 29, 12, 30, 31, 1));
        pending_readings.push_back(make_reading(2001, 2, 29, 1, 2, 3, 1));
        pending_readings.push_back(make_reading(2001, 2, 28, 1, 2, 3, 1));
        pending_readings.push_back(make_reading(2004, 2, 29, 8, 0, 1, 1));
        pending_readings.push_back(make_reading(2004, 3, 1, 0, 0, 0, 1));
        pending_readings.push_back(make_reading(1999, 12, 31, 23, 59, 59, 1));
        pending_readings.push_back(make_reading(2100, 1, 1, 0, 0, 0, 1));
        pending_readings.push_back(make_reading(0, 0, 0, 0, 0, 0, 0));
        pending_readings.push_back(make_reading(65535, 255, 255, 255, 255, 255, 1));
        pending_readings.push_back(make_reading(2020, 0, 10, 10, 10, 10, 1));
        pending_readings.push_back(make_reading(2020, 13, 10, 10, 10, 10, 1));
        pending_readings.push_back(make_reading(2020, 5, 0, 10, 10, 10, 1));
        pending_readings.push_back(make_reading(2021, 1, 32, 10, 10, 10, 1));
        pending_readings.push_back(make_reading(2021, 4, 31, 10, 10, 10, 1));
        pending_readings.push_back(make_reading(2021, 4, 30, 24, 10, 10, 1));
        pending_readings.push_back(make_reading(2021, 4, 30, 23, 60, 10, 1));
        pending_readings.push_back(make_reading(2021, 4, 30, 23, 59, 60, 1));
        pending_readings.push_back(make_reading(2050, 6, 15, 14, 45, 7, 0));
        pending_readings.push_back(make_reading(2077, 11, 11, 11, 11, 59, 1));
        pending_readings.push_back(make_reading(2001, 1, 1, 0, 0, 1, 1));
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pending_readings.push_back(random_reading());
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_readings.size() != 0 || s_axis_tvalid) @(negedge aclk);
        while (expected_stamps.size() != 0) @(negedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    always @(posedge aclk) begin
        reading_t rd;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                s_gap <= s_gap - 1;
            end else if (pending_readings.size() != 0) begin
                rd = pending_readings.pop_front();
                s_axis_tdata <= {rd.second, rd.minute, rd.hour, rd.day, rd.month, rd.year};
                s_axis_tuser <= rd.marked;
                s_axis_tvalid <= 1'b1;
                if (s_calm > 0) begin
                    s_calm <= s_calm - 1;
                    s_gap <= 0;
                end else if ($urandom_range(0, 99) < 4) begin
                    s_calm <= $urandom_range(30, 80);
                    s_gap <= 0;
                end else begin
                    s_gap <= gap_length();
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // The long hold-off lets the pipeline fill up and stall its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && taken_count >= 150) begin
            m_axis_tready <= 1'b0;
            hold_done <= 1'b1;
            hold_left <= 300;
        end else if (m_stall > 0) begin
            m_axis_tready <= 1'b0;
            m_stall <= m_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (m_calm > 0) begin
                m_calm <= m_calm - 1;
            end else if ($urandom_range(0, 99) < 4) begin
                m_calm <= $urandom_range(30, 80);
            end else begin
                m_stall <= gap_length();
            end
        end
    end

    always @(posedge aclk) begin
        reading_t rd;
        stamp_t   want;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                rd.year = s_axis_tdata[15:0];
                rd.month = s_axis_tdata[23:16];
                rd.day = s_axis_tdata[31:24];
                rd.hour = s_axis_tdata[39:32];
                rd.minute = s_axis_tdata[47:40];
                rd.second = s_axis_tdata[55:48];
                rd.marked = s_axis_tuser;
                expected_stamps.push_back(predict_stamp(rd));
                taken_count++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_stamps.size() == 0) begin
                    report_mismatch("unexpected result transaction", m_axis_tdata[31:0], '0);
                end else begin
                    want = expected_stamps.pop_front();
                    if (m_axis_tuser !== want.calendar_ok) begin
                        report_mismatch("calendar_ok", 32'(m_axis_tuser),
                                        32'(want.calendar_ok));
                    end
                    if (m_axis_tdata[31:0] !== want.fat_stamp) begin
                        report_mismatch("fat_stamp", m_axis_tdata[31:0], want.fat_stamp);
                    end
                    if (m_axis_tdata[34:32] !== want.weekday) begin
                        report_mismatch("weekday", 32'(m_axis_tdata[34:32]),
                                        32'(want.weekday));
                    end
                    if (m_axis_tdata[50:35] !== want.days_since_2000) begin
                        report_mismatch("days_since_2000", 32'(m_axis_tdata[50:35]),
                                        32'(want.days_since_2000));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/ucfs_pkg.sv
rtl/core/ucfs_check.sv
rtl/core/ucfs_days.sv
rtl/core/ucfs_pack.sv
rtl/core/utc_calendar_check_and_fat_stamp_top.sv
test/tb.sv
